// ===== rtl/sst_pkg.sv =====
// Shared types and codes for the session state table with port locks.
// Used by sst_ctrl, sst_mem and session_state_table_with_locks_unit; depends on nothing.
package sst_pkg;

   localparam int SID_W = 10;
   localparam int ST_W = 4;
   localparam logic [ST_W-1:0] ST_CLOSED = 4'd0;

   typedef enum logic [2:0] {
      ACT_NONE      = 3'd0,
      ACT_TX_UPD    = 3'd1,
      ACT_TX_READ   = 3'd2,
      ACT_RX_UPD    = 3'd3,
      ACT_RELEASE   = 3'd4,
      ACT_TX_RETRY  = 3'd5,
      ACT_RX_RETRY  = 3'd6,
      ACT_REL_RETRY = 3'd7
   } action_type;

   typedef enum logic [1:0] {
      PORT_NONE    = 2'd0,
      PORT_TX_UPD  = 2'd1,
      PORT_TX_READ = 2'd2,
      PORT_RX_UPD  = 2'd3
   } port_type;

   typedef struct packed {
      logic             tx_upd_valid;
      logic             tx_upd_write;
      logic [SID_W-1:0] tx_upd_session;
      logic [ST_W-1:0]  tx_upd_state;
      logic             tx_read_valid;
      logic [SID_W-1:0] tx_read_session;
      logic             rx_upd_valid;
      logic             rx_upd_write;
      logic [SID_W-1:0] rx_upd_session;
      logic [ST_W-1:0]  rx_upd_state;
      logic             release_valid;
      logic [SID_W-1:0] release_session;
   } req_item_type;

   typedef struct packed {
      action_type       action;
      port_type         response_port;
      logic [ST_W-1:0]  response_state;
      logic             release_out_valid;
      logic [SID_W-1:0] release_out_session;
   } rsp_item_type;

   typedef struct packed {
      logic             write;
      logic [SID_W-1:0] session;
      logic [ST_W-1:0]  state;
   } park_type;

   typedef struct packed {
      logic             rd;
      logic             wr;
      logic [SID_W-1:0] sid;
      logic [ST_W-1:0]  wdata;
   } mem_op_type;

   typedef struct packed {
      mem_op_type       mem;
      action_type       action;
      port_type         response_port;
      logic             release_out_valid;
      logic [SID_W-1:0] release_out_session;
   } ctrl_out_type;

endpackage

// ===== rtl/session_state_table_with_locks_unit.sv =====
// Session state table with port locks: top level with the result register.
// Each accepted item gives its result in the next cycle, set by the memory's registered read.
// One item is accepted per cycle outside the sweep; the result register lets a new item in while rsp_stall is low.
// After reset the memory sweeps every session to closed, with req_stall held high.
// Depends on sst_pkg, sst_ctrl and sst_mem.
module session_state_table_with_locks_unit #(
   parameter int SESSIONS = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  sst_pkg::req_item_type req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output sst_pkg::rsp_item_type rsp_item
);

   logic                     fire;
   logic                     mem_busy;
   logic [sst_pkg::ST_W-1:0] mem_rdata;
   sst_pkg::ctrl_out_type    ctrl_out;
   sst_pkg::mem_op_type      mem_op;
   logic                     out_valid_ff;
   logic                     out_valid_in;
   sst_pkg::ctrl_out_type    out_ff;

   assign req_stall = mem_busy || (out_valid_ff && rsp_stall);
   assign fire      = req_valid && !req_stall;

   sst_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .fire     (fire),
      .req      (req_item),
      .ctrl_out (ctrl_out)
   );

   always_comb begin
      mem_op    = ctrl_out.mem;
      mem_op.rd = fire && ctrl_out.mem.rd;
      mem_op.wr = fire && ctrl_out.mem.wr;
   end

   sst_mem #(
      .SESSIONS (SESSIONS)
   ) u_mem (
      .clock (clock),
      .reset (reset),
      .op    (mem_op),
      .busy  (mem_busy),
      .rdata (mem_rdata)
   );

   assign out_valid_in = fire || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_ff <= ctrl_out;
      end
   end

   always_comb begin
      rsp_item.action              = out_ff.action;
      rsp_item.response_port       = out_ff.response_port;
      rsp_item.response_state      = (out_ff.response_port == sst_pkg::PORT_NONE)
                                     ? sst_pkg::ST_CLOSED : mem_rdata;
      rsp_item.release_out_valid   = out_ff.release_out_valid;
      rsp_item.release_out_session = out_ff.release_out_session;
   end

   assign rsp_valid = out_valid_ff;

endmodule

// ===== rtl/sst_mem.sv =====
// Session state memory with a registered read and a clearing sweep after reset.
// Depends on sst_pkg.
module sst_mem #(
   parameter int SESSIONS = 1024
) (
   input  logic                     clock,
   input  logic                     reset,
   input  sst_pkg::mem_op_type      op,
   output logic                     busy,
   output logic [sst_pkg::ST_W-1:0] rdata
);

   localparam int AW = $clog2(SESSIONS);
   localparam logic [AW-1:0] LAST_ADDR = AW'(SESSIONS - 1);

   logic [sst_pkg::ST_W-1:0] mem [SESSIONS];
   logic                     clr_busy_ff;
   logic                     clr_busy_in;
   logic [AW-1:0]            clr_addr_ff;
   logic [AW-1:0]            clr_addr_in;
   logic [sst_pkg::ST_W-1:0] rd_ff;
   logic                     oob_ff;
   logic                     in_range;
   logic [AW-1:0]            op_addr;
   logic                     wr_en;
   logic [AW-1:0]            wr_addr;
   logic [sst_pkg::ST_W-1:0] wr_data;

   assign in_range = (32'(op.sid) < 32'(SESSIONS));
   assign op_addr  = AW'(op.sid);

   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_busy_ff) begin
         if (clr_addr_ff == LAST_ADDR) begin
            clr_busy_in = 1'b0;
         end else begin
            clr_addr_in = clr_addr_ff + AW'(1);
         end
      end
      wr_en   = clr_busy_ff || (op.wr && in_range);
      wr_addr = clr_busy_ff ? clr_addr_ff : op_addr;
      wr_data = clr_busy_ff ? sst_pkg::ST_CLOSED : op.wdata;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (op.rd) begin
         rd_ff  <= mem[op_addr];
         oob_ff <= !in_range;
      end
   end

   assign busy  = clr_busy_ff;
   assign rdata = oob_ff ? sst_pkg::ST_CLOSED : rd_ff;

endmodule

// ===== rtl/sst_ctrl.sv =====
// Request arbitration, port locks and parked requests of the session state table.
// Depends on sst_pkg.
module sst_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  sst_pkg::req_item_type req,
   output sst_pkg::ctrl_out_type ctrl_out
);

   logic                      tx_locked_ff, tx_locked_in;
   logic [sst_pkg::SID_W-1:0] tx_lock_sid_ff, tx_lock_sid_in;
   logic                      rx_locked_ff, rx_locked_in;
   logic [sst_pkg::SID_W-1:0] rx_lock_sid_ff, rx_lock_sid_in;
   logic                      tx_parked_ff, tx_parked_in;
   sst_pkg::park_type         tx_park_ff, tx_park_in;
   logic                      rx_parked_ff, rx_parked_in;
   sst_pkg::park_type         rx_park_ff, rx_park_in;
   logic                      rel_parked_ff, rel_parked_in;
   logic [sst_pkg::SID_W-1:0] rel_park_sid_ff, rel_park_sid_in;

   sst_pkg::park_type         new_tx;
   sst_pkg::park_type         new_rx;
   logic                      serve_tx;
   logic                      serve_rx;
   logic                      serve_rel;
   sst_pkg::park_type         tx_sel;
   sst_pkg::park_type         rx_sel;
   logic [sst_pkg::SID_W-1:0] rel_sid;
   logic                      tx_blk_new;
   logic                      rx_blk_new;
   logic                      rel_blk_new;
   logic                      tx_blk_park;
   logic                      rx_blk_park;
   logic                      rel_blk_park;
   sst_pkg::ctrl_out_type     out_d;

   assign new_tx = '{write: req.tx_upd_write, session: req.tx_upd_session,
                     state: req.tx_upd_state};
   assign new_rx = '{write: req.rx_upd_write, session: req.rx_upd_session,
                     state: req.rx_upd_state};

   assign tx_blk_new  = rx_locked_ff && (req.tx_upd_session == rx_lock_sid_ff);
   assign rx_blk_new  = tx_locked_ff && (req.rx_upd_session == tx_lock_sid_ff);
   assign rel_blk_new = (rx_locked_ff && (req.release_session == rx_lock_sid_ff))
                     || (tx_locked_ff && (req.release_session == tx_lock_sid_ff));
   assign tx_blk_park  = rx_locked_ff && (tx_park_ff.session == rx_lock_sid_ff);
   assign rx_blk_park  = tx_locked_ff && (rx_park_ff.session == tx_lock_sid_ff);
   assign rel_blk_park = (rx_locked_ff && (rel_park_sid_ff == rx_lock_sid_ff))
                      || (tx_locked_ff && (rel_park_sid_ff == tx_lock_sid_ff));

   always_comb begin
      tx_locked_in    = tx_locked_ff;
      tx_lock_sid_in  = tx_lock_sid_ff;
      rx_locked_in    = rx_locked_ff;
      rx_lock_sid_in  = rx_lock_sid_ff;
      tx_parked_in    = tx_parked_ff;
      tx_park_in      = tx_park_ff;
      rx_parked_in    = rx_parked_ff;
      rx_park_in      = rx_park_ff;
      rel_parked_in   = rel_parked_ff;
      rel_park_sid_in = rel_park_sid_ff;
      serve_tx  = 1'b0;
      serve_rx  = 1'b0;
      serve_rel = 1'b0;
      tx_sel    = new_tx;
      rx_sel    = new_rx;
      rel_sid   = req.release_session;
      out_d                     = '0;
      out_d.action              = sst_pkg::ACT_NONE;
      out_d.response_port       = sst_pkg::PORT_NONE;

      if (req.tx_upd_valid && !tx_parked_ff) begin
         out_d.action = sst_pkg::ACT_TX_UPD;
         if (tx_blk_new) begin
            tx_parked_in = 1'b1;
            tx_park_in   = new_tx;
         end else begin
            serve_tx = 1'b1;
         end
      end else if (req.tx_read_valid) begin
         out_d.action        = sst_pkg::ACT_TX_READ;
         out_d.response_port = sst_pkg::PORT_TX_READ;
         out_d.mem.rd        = 1'b1;
         out_d.mem.sid       = req.tx_read_session;
      end else if (req.rx_upd_valid && !rx_parked_ff) begin
         out_d.action = sst_pkg::ACT_RX_UPD;
         if (rx_blk_new) begin
            rx_parked_in = 1'b1;
            rx_park_in   = new_rx;
         end else begin
            serve_rx = 1'b1;
         end
      end else if (req.release_valid && !rel_parked_ff) begin
         out_d.action = sst_pkg::ACT_RELEASE;
         if (rel_blk_new) begin
            rel_parked_in   = 1'b1;
            rel_park_sid_in = req.release_session;
         end else begin
            serve_rel = 1'b1;
         end
      end else if (tx_parked_ff) begin
         if (!tx_blk_park) begin
            out_d.action = sst_pkg::ACT_TX_RETRY;
            serve_tx     = 1'b1;
            tx_sel       = tx_park_ff;
            tx_parked_in = 1'b0;
         end
      end else if (rx_parked_ff) begin
         if (!rx_blk_park) begin
            out_d.action = sst_pkg::ACT_RX_RETRY;
            serve_rx     = 1'b1;
            rx_sel       = rx_park_ff;
            rx_parked_in = 1'b0;
         end
      end else if (rel_parked_ff) begin
         if (!rel_blk_park) begin
            out_d.action  = sst_pkg::ACT_REL_RETRY;
            serve_rel     = 1'b1;
            rel_sid       = rel_park_sid_ff;
            rel_parked_in = 1'b0;
         end
      end

      if (serve_tx) begin
         out_d.mem.sid = tx_sel.session;
         if (tx_sel.write) begin
            out_d.mem.wr    = 1'b1;
            out_d.mem.wdata = tx_sel.state;
            tx_locked_in    = 1'b0;
         end else begin
            out_d.mem.rd        = 1'b1;
            out_d.response_port = sst_pkg::PORT_TX_UPD;
            tx_locked_in        = 1'b1;
            tx_lock_sid_in      = tx_sel.session;
         end
      end

      if (serve_rx) begin
         out_d.mem.sid = rx_sel.session;
         if (rx_sel.write) begin
            out_d.mem.wr    = 1'b1;
            out_d.mem.wdata = rx_sel.state;
            rx_locked_in    = 1'b0;
            if (rx_sel.state == sst_pkg::ST_CLOSED) begin
               out_d.release_out_valid   = 1'b1;
               out_d.release_out_session = rx_sel.session;
            end
         end else begin
            out_d.mem.rd        = 1'b1;
            out_d.response_port = sst_pkg::PORT_RX_UPD;
            rx_locked_in        = 1'b1;
            rx_lock_sid_in      = rx_sel.session;
         end
      end

      if (serve_rel) begin
         out_d.mem.sid             = rel_sid;
         out_d.mem.wr              = 1'b1;
         out_d.mem.wdata           = sst_pkg::ST_CLOSED;
         out_d.release_out_valid   = 1'b1;
         out_d.release_out_session = rel_sid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tx_locked_ff    <= 1'b0;
         tx_lock_sid_ff  <= '0;
         rx_locked_ff    <= 1'b0;
         rx_lock_sid_ff  <= '0;
         tx_parked_ff    <= 1'b0;
         tx_park_ff      <= '0;
         rx_parked_ff    <= 1'b0;
         rx_park_ff      <= '0;
         rel_parked_ff   <= 1'b0;
         rel_park_sid_ff <= '0;
      end else if (fire) begin
         tx_locked_ff    <= tx_locked_in;
         tx_lock_sid_ff  <= tx_lock_sid_in;
         rx_locked_ff    <= rx_locked_in;
         rx_lock_sid_ff  <= rx_lock_sid_in;
         tx_parked_ff    <= tx_parked_in;
         tx_park_ff      <= tx_park_in;
         rx_parked_ff    <= rx_parked_in;
         rx_park_ff      <= rx_park_in;
         rel_parked_ff   <= rel_parked_in;
         rel_park_sid_ff <= rel_park_sid_in;
      end
   end

   assign ctrl_out = out_d;

endmodule
